// ===== hw/rtl/ufe_pkg.sv =====
package ufe_pkg;

	// Fixed widths of the request and response fields.
	localparam int FIELD_W = 10;
	localparam int OP_W = 2;
	localparam int SIZE_W = 11;
	localparam int RANK_W = 4;

	// Width that holds any element index and the table depth itself.
	localparam int EXT_W = 17;

	// Default table depth.
	localparam int ELEMENTS_DEF = 1024;

	// Saturation limits of the per-root bookkeeping.
	localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd2047;
	localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_FIND = 2'd0;
	localparam logic [OP_W-1:0] OP_CONNECTED = 2'd1;
	localparam logic [OP_W-1:0] OP_UNION_SIZE = 2'd2;
	localparam logic [OP_W-1:0] OP_UNION_RANK = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [FIELD_W-1:0] first_element;
		logic [FIELD_W-1:0] second_element;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] root_first;
		logic [FIELD_W-1:0] root_second;
		logic same_set;
		logic merged;
	} rsp_t;

endpackage

// ===== hw/rtl/ufe_ram.sv =====
module ufe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/union_find_engine.sv =====
// Union-find engine with path compression over a table of ELEMENTS entries, each holding a
// parent link, a set size and a rank. A request is taken only while req_stall is low and is
// worked on alone; a find on an element below its root reads every node on the path once
// through the table's single read port to reach the root and again while it is relinked
// to the root. Connected and the unions walk both elements one after the other, and a union
// that joins two sets adds two table writes. Requests naming an element outside the table
// finish with an all-zero response. After reset the engine clears the table, one entry a
// cycle, and holds req_stall high meanwhile.
module union_find_engine #(
	parameter int ELEMENTS = ufe_pkg::ELEMENTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input ufe_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output ufe_pkg::rsp_t rsp
);

	localparam int AW = $clog2(ELEMENTS);
	localparam int FW = ufe_pkg::FIELD_W;
	localparam int SW = ufe_pkg::SIZE_W;
	localparam int RW = ufe_pkg::RANK_W;
	localparam int EW = ufe_pkg::EXT_W;
	localparam int DW = AW + SW + RW;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_CHK = 4'd3;
	localparam logic [3:0] S_CRD = 4'd4;
	localparam logic [3:0] S_CCHK = 4'd5;
	localparam logic [3:0] S_JOIN = 4'd6;
	localparam logic [3:0] S_LINK = 4'd7;
	localparam logic [3:0] S_GROW = 4'd8;
	localparam logic [3:0] S_FIN = 4'd9;

	typedef struct packed {
		logic [AW-1:0] parent;
		logic [SW-1:0] size;
		logic [RW-1:0] rank;
	} entry_t;

	logic [3:0] state_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] u_q;
	logic [AW-1:0] v_q;
	logic [ufe_pkg::OP_W-1:0] op_q;
	logic bad_q;
	logic phase_q;
	logic [AW-1:0] ra_q;
	logic [AW-1:0] rb_q;
	logic [SW-1:0] sa_q;
	logic [SW-1:0] sb_q;
	logic [RW-1:0] ka_q;
	logic [RW-1:0] kb_q;
	logic out_valid_q;
	ufe_pkg::rsp_t rsp_q;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	entry_t wr_data;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rd_raw;
	entry_t rd_e;

	logic req_bad;
	logic [AW-1:0] start_w;
	logic [AW-1:0] root_w;
	logic root_hit;
	logic walk_end;
	logic a_loses;
	logic [AW-1:0] big_w;
	logic [AW-1:0] small_w;
	logic [SW-1:0] big_size;
	logic [SW-1:0] small_size;
	logic [RW-1:0] big_rank;
	logic [RW-1:0] small_rank;
	logic [SW:0] size_sum;
	logic [SW-1:0] new_size;
	logic [RW-1:0] new_rank;
	logic out_load;
	ufe_pkg::rsp_t rsp_d;

	// Node table: parent link, size and rank of each element.
	ufe_ram #(
		.WIDTH(DW),
		.DEPTH(ELEMENTS)
	) u_table (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	assign rd_e = rd_raw;

	// A request is flagged bad if an element it uses lies outside the table.
	assign req_bad = (EW'(req.first_element) >= EW'(ELEMENTS)) ||
		((req.op != ufe_pkg::OP_FIND) && (EW'(req.second_element) >= EW'(ELEMENTS)));

	// Walk bookkeeping for the element currently being resolved.
	assign start_w = phase_q ? v_q : u_q;
	assign root_w = phase_q ? rb_q : ra_q;
	assign root_hit = (rd_e.parent == cur_q);
	assign walk_end = ((state_q == S_CHK) && root_hit && (cur_q == start_w)) ||
		((state_q == S_CCHK) && (rd_e.parent == root_w));

	// Pick which root stays on top; the first root wins ties.
	always_comb begin
		if (op_q == ufe_pkg::OP_UNION_SIZE) begin
			a_loses = (sa_q < sb_q);
		end else begin
			a_loses = (ka_q < kb_q);
		end
		big_w = a_loses ? rb_q : ra_q;
		small_w = a_loses ? ra_q : rb_q;
		big_size = a_loses ? sb_q : sa_q;
		small_size = a_loses ? sa_q : sb_q;
		big_rank = a_loses ? kb_q : ka_q;
		small_rank = a_loses ? ka_q : kb_q;
		size_sum = {1'b0, big_size} + {1'b0, small_size};
		new_size = big_size;
		new_rank = big_rank;
		if (op_q == ufe_pkg::OP_UNION_SIZE) begin
			new_size = (size_sum > {1'b0, ufe_pkg::SIZE_MAX}) ? ufe_pkg::SIZE_MAX :
				size_sum[SW-1:0];
		end else if ((big_rank == small_rank) && (big_rank < ufe_pkg::RANK_MAX)) begin
			new_rank = big_rank + 1'b1;
		end
	end

	// Table port control for each sequencer step.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_data = rd_e;
		rd_addr = cur_q;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_data.parent = cur_q;
				wr_data.size = SW'(1);
				wr_data.rank = '0;
			end
			S_CHK: begin
				if (!root_hit) begin
					rd_addr = rd_e.parent;
				end
			end
			S_CCHK: begin
				wr_en = 1'b1;
				wr_data.parent = root_w;
				rd_addr = rd_e.parent;
			end
			S_LINK: begin
				wr_en = 1'b1;
				wr_addr = small_w;
				wr_data.parent = big_w;
				wr_data.size = small_size;
				wr_data.rank = small_rank;
			end
			S_GROW: begin
				wr_en = 1'b1;
				wr_addr = big_w;
				wr_data.parent = big_w;
				wr_data.size = new_size;
				wr_data.rank = new_rank;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_q <= '0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					cur_q <= AW'(cur_q + 1'b1);
					if (cur_q == AW'(ELEMENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						phase_q <= 1'b0;
						cur_q <= AW'(req.first_element);
						state_q <= req_bad ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!root_hit) begin
						cur_q <= rd_e.parent;
					end else if (cur_q != start_w) begin
						cur_q <= start_w;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CCHK;
				end
				S_CCHK: begin
					// The last node below the root ends the walk below.
					if (rd_e.parent != root_w) begin
						cur_q <= rd_e.parent;
					end
				end
				S_JOIN: begin
					if (((op_q == ufe_pkg::OP_UNION_SIZE) || (op_q == ufe_pkg::OP_UNION_RANK))
						&& (ra_q != rb_q)) begin
						state_q <= S_LINK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LINK: begin
					state_q <= S_GROW;
				end
				S_GROW: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Leaving a walk: go on to the second element or to the decision.
			if (walk_end) begin
				if (phase_q) begin
					state_q <= S_JOIN;
				end else if (op_q == ufe_pkg::OP_FIND) begin
					state_q <= S_FIN;
				end else begin
					phase_q <= 1'b1;
					cur_q <= v_q;
					state_q <= S_RD;
				end
			end
		end
	end

	// Request fields and the roots found with their size and rank.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			op_q <= req.op;
			bad_q <= req_bad;
			u_q <= AW'(req.first_element);
			v_q <= AW'(req.second_element);
		end
		if ((state_q == S_CHK) && root_hit) begin
			if (phase_q) begin
				rb_q <= cur_q;
				sb_q <= rd_e.size;
				kb_q <= rd_e.rank;
			end else begin
				ra_q <= cur_q;
				sa_q <= rd_e.size;
				ka_q <= rd_e.rank;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// Response assembly.
	always_comb begin
		rsp_d.root_first = bad_q ? '0 : FW'(ra_q);
		rsp_d.root_second = (bad_q || (op_q == ufe_pkg::OP_FIND)) ? '0 : FW'(rb_q);
		rsp_d.same_set = !bad_q && (op_q != ufe_pkg::OP_FIND) && (ra_q == rb_q);
		rsp_d.merged = !bad_q && ((op_q == ufe_pkg::OP_UNION_SIZE) ||
			(op_q == ufe_pkg::OP_UNION_RANK)) && (ra_q != rb_q);
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || !rsp_stall);

	// Output register; it frees once its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

	// An accepted request always starts work on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != S_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// The table is never written while waiting for a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("table written while idle");

	// A link is only made between two distinct roots.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK) |-> (ra_q != rb_q))
		else $error("link between equal roots");

	// A merge never reports the two elements as already in one set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.merged) |-> (!rsp.same_set && (rsp.root_first != rsp.root_second)))
		else $error("merge reported with equal roots");

	// The grow step always follows the link step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GROW) |-> ($past(state_q) == S_LINK))
		else $error("root update without link");

endmodule
